// ----- sv/vertex_perspective_transform_assert.svh -----
// Assertion helpers for the top-level RTL file.
`ifndef VERTEX_PERSPECTIVE_TRANSFORM_ASSERT_SVH
`define VERTEX_PERSPECTIVE_TRANSFORM_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define VPT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vpt assertion failed");

// Next-cycle implication, checked outside reset.
`define VPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vpt assertion failed");

`else

`define VPT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define VPT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/vpt_pkg.sv -----
package vpt_pkg;

   localparam int FRAC_BITS = 16;
   // Quotient bits kept by the projection divider; the result caps at 2^(QBITS-1).
   localparam int QBITS     = 34;
   localparam int ROW_LAT   = 3;
   localparam int DIV_LAT   = QBITS + 4;
   localparam int TOTAL_LAT = ROW_LAT + DIV_LAT;

   localparam logic [2:0] CSR_X_ROW_XY     = 3'd0;
   localparam logic [2:0] CSR_X_ROW_ZT     = 3'd1;
   localparam logic [2:0] CSR_Y_ROW_XY     = 3'd2;
   localparam logic [2:0] CSR_Y_ROW_ZT     = 3'd3;
   localparam logic [2:0] CSR_Z_ROW_XY     = 3'd4;
   localparam logic [2:0] CSR_Z_ROW_ZT     = 3'd5;
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd6;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd7;

   localparam logic [63:0] RST_X_ROW_XY = 64'h0000_0000_0001_0000;
   localparam logic [63:0] RST_X_ROW_ZT = 64'h0;
   localparam logic [63:0] RST_Y_ROW_XY = 64'h0001_0000_0000_0000;
   localparam logic [63:0] RST_Y_ROW_ZT = 64'h0;
   localparam logic [63:0] RST_Z_ROW_XY = 64'h0;
   localparam logic [63:0] RST_Z_ROW_ZT = 64'h0000_0000_0001_0000;
   localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
   localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clamp;
   } sat_type;

   typedef struct packed {
      logic signed [31:0] depth;
      logic               zero;
      logic               clamp;
   } side_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > SAT_MAX) begin
         r.value = 32'sh7FFF_FFFF;
         r.clamp = 1'b1;
      end else if (v < SAT_MIN) begin
         r.value = 32'sh8000_0000;
         r.clamp = 1'b1;
      end else begin
         r.value = 32'(v);
         r.clamp = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- sv/vpt_row.sv -----
module vpt_row (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [31:0] obj_x,
   input  logic signed [31:0] obj_y,
   input  logic signed [31:0] obj_z,
   input  logic        [63:0] row_xy,
   input  logic        [63:0] row_zt,
   output vpt_pkg::sat_type   result
);

   logic signed [31:0] w_x, w_y, w_z, trans;
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p0_in, p1_in, p2_in;
   logic signed [65:0] sum_ff, sum_in;
   vpt_pkg::sat_type   res_ff, res_in;

   assign w_x   = row_xy[31:0];
   assign w_y   = row_xy[63:32];
   assign w_z   = row_zt[31:0];
   assign trans = row_zt[63:32];

   always_comb begin
      p0_in  = obj_x * w_x;
      p1_in  = obj_y * w_y;
      p2_in  = obj_z * w_z;
      sum_in = 66'(p0_ff) + 66'(p1_ff) + 66'(p2_ff);
      // floor of the exact Q32.32 sum, then translate
      res_in = vpt_pkg::sat32(64'(sum_ff >>> vpt_pkg::FRAC_BITS) + 64'(trans));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         sum_ff <= sum_in;
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ----- sv/vpt_div.sv -----
module vpt_div #(
   parameter int FOCAL_SCALE = 500
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [31:0]          coord,
   input  logic signed [31:0]          depth,
   output logic signed [vpt_pkg::QBITS:0] quot
);

   localparam int QB    = vpt_pkg::QBITS;
   localparam int SHIFT = vpt_pkg::QBITS - vpt_pkg::FRAC_BITS;
   localparam int SW    = $clog2(FOCAL_SCALE + 1);
   localparam int PW    = 32 + SW;
   localparam int CMPW  = (PW > 32 + SHIFT) ? PW : 32 + SHIFT;
   localparam logic [QB-1:0] QCAP = QB'(1) << (QB - 1);

   // stage A: magnitudes
   logic [31:0] mt_a_ff, mz_a_ff, mt_a_in, mz_a_in;
   logic        neg_a_ff, neg_a_in;
   // stage B: scaled numerator
   logic [PW-1:0] p_b_ff, p_b_in;
   logic [31:0]   mz_b_ff;
   logic          neg_b_ff;
   // bit stages, index 0 is the seed stage
   logic [31:0]      rem_ff  [QB+1];
   logic [31:0]      mz_ff   [QB+1];
   logic [SHIFT-1:0] plow_ff [QB+1];
   logic [QB-1:0]    q_ff    [QB+1];
   logic             neg_ff  [QB+1];
   logic             ovf_ff  [QB+1];
   logic             ovf_in;
   logic [QB-1:0]    qcap;
   logic signed [QB:0] quot_ff, quot_in;

   always_comb begin
      mt_a_in  = coord[31] ? (~coord + 32'd1) : coord;
      mz_a_in  = depth[31] ? (~depth + 32'd1) : depth;
      neg_a_in = coord[31] ^ depth[31];
      p_b_in   = PW'(mt_a_ff) * PW'(FOCAL_SCALE);
      // quotient needs more than QB bits
      ovf_in   = CMPW'(p_b_ff) >= CMPW'({mz_b_ff, {SHIFT{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mt_a_ff    <= mt_a_in;
         mz_a_ff    <= mz_a_in;
         neg_a_ff   <= neg_a_in;
         p_b_ff     <= p_b_in;
         mz_b_ff    <= mz_a_ff;
         neg_b_ff   <= neg_a_ff;
         rem_ff[0]  <= 32'(p_b_ff >> SHIFT);
         plow_ff[0] <= p_b_ff[SHIFT-1:0];
         mz_ff[0]   <= mz_b_ff;
         q_ff[0]    <= '0;
         neg_ff[0]  <= neg_b_ff;
         ovf_ff[0]  <= ovf_in;
      end
   end

   for (genvar s = 0; s < QB; s++) begin : g_bit
      localparam int K = QB - 1 - s;
      logic [32:0]   rsh;
      logic          ge;
      logic [31:0]   rem_in;
      logic [QB-1:0] q_in;
      logic          nb;

      if (K >= vpt_pkg::FRAC_BITS) begin : g_num
         assign nb = plow_ff[s][K - vpt_pkg::FRAC_BITS];
      end else begin : g_frac
         assign nb = 1'b0;
      end

      always_comb begin
         rsh    = {rem_ff[s], nb};
         ge     = rsh >= {1'b0, mz_ff[s]};
         rem_in = ge ? 32'(rsh - {1'b0, mz_ff[s]}) : rsh[31:0];
         q_in    = q_ff[s];
         q_in[K] = ge;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s+1]  <= rem_in;
            mz_ff[s+1]   <= mz_ff[s];
            plow_ff[s+1] <= plow_ff[s];
            q_ff[s+1]    <= q_in;
            neg_ff[s+1]  <= neg_ff[s];
            ovf_ff[s+1]  <= ovf_ff[s];
         end
      end
   end

   always_comb begin
      qcap    = (ovf_ff[QB] || (q_ff[QB] > QCAP)) ? QCAP : q_ff[QB];
      quot_in = neg_ff[QB] ? -$signed({1'b0, qcap}) : $signed({1'b0, qcap});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

// ----- sv/vertex_perspective_transform.sv -----
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   obj_x, obj_y, obj_z, last_vertex
// rsp      out        rsp_valid / rsp_stall   screen_x, screen_y, depth_z,
//                                             zero_depth, clamped, last_out
// csr      in         csr_write               csr_index, csr_data
//
// One vertex per cycle while the output is not stalled; transform rows, divider, output register.
// The divider retires one quotient bit per stage, 34 stages; the depth runs beside it.
// A stalled output word freezes the whole pipeline, so req_stall follows it.
// Reset clears the valid bits and loads the identity matrix and a 640x480 frame.
module vertex_perspective_transform #(
   parameter int FOCAL_SCALE = 500
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_obj_x,
   input  logic signed [31:0] req_obj_y,
   input  logic signed [31:0] req_obj_z,
   input  logic               req_last_vertex,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   output logic signed [31:0] rsp_depth_z,
   output logic               rsp_zero_depth,
   output logic               rsp_clamped,
   output logic               rsp_last_out,
   input  logic               csr_write,
   input  logic        [2:0]  csr_index,
   input  logic        [63:0] csr_data
);

   `include "vertex_perspective_transform_assert.svh"

   localparam int TOT = vpt_pkg::TOTAL_LAT;
   localparam int DL  = vpt_pkg::DIV_LAT;

   logic [63:0] x_xy_ff, x_zt_ff, y_xy_ff, y_zt_ff, z_xy_ff, z_zt_ff;
   logic [12:0] width_ff, height_ff;

   logic           adv;
   logic [TOT-1:0] vld_ff, last_ff;
   vpt_pkg::sat_type  tx, ty, tz;
   vpt_pkg::side_type side_ff [DL];
   vpt_pkg::side_type side_in;
   logic signed [vpt_pkg::QBITS:0] qx, qy;
   logic signed [35:0] cx, cy, sum_x, sum_y;
   vpt_pkg::sat_type   sx, sy;
   vpt_pkg::side_type  side_out;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] scr_x_ff, scr_x_in, scr_y_ff, scr_y_in, dep_ff;
   logic               zero_ff, clamp_ff, clamp_in, last_out_ff;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_xy_ff   <= vpt_pkg::RST_X_ROW_XY;
         x_zt_ff   <= vpt_pkg::RST_X_ROW_ZT;
         y_xy_ff   <= vpt_pkg::RST_Y_ROW_XY;
         y_zt_ff   <= vpt_pkg::RST_Y_ROW_ZT;
         z_xy_ff   <= vpt_pkg::RST_Z_ROW_XY;
         z_zt_ff   <= vpt_pkg::RST_Z_ROW_ZT;
         width_ff  <= vpt_pkg::RST_FRAME_WIDTH;
         height_ff <= vpt_pkg::RST_FRAME_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_index)
            vpt_pkg::CSR_X_ROW_XY:     x_xy_ff   <= csr_data;
            vpt_pkg::CSR_X_ROW_ZT:     x_zt_ff   <= csr_data;
            vpt_pkg::CSR_Y_ROW_XY:     y_xy_ff   <= csr_data;
            vpt_pkg::CSR_Y_ROW_ZT:     y_zt_ff   <= csr_data;
            vpt_pkg::CSR_Z_ROW_XY:     z_xy_ff   <= csr_data;
            vpt_pkg::CSR_Z_ROW_ZT:     z_zt_ff   <= csr_data;
            vpt_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data[12:0];
            vpt_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data[12:0];
         endcase
      end
   end

   // advance everything unless the output word is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   vpt_row u_row_x (
      .clock(clock), .enable(adv),
      .obj_x(req_obj_x), .obj_y(req_obj_y), .obj_z(req_obj_z),
      .row_xy(x_xy_ff), .row_zt(x_zt_ff), .result(tx)
   );

   vpt_row u_row_y (
      .clock(clock), .enable(adv),
      .obj_x(req_obj_x), .obj_y(req_obj_y), .obj_z(req_obj_z),
      .row_xy(y_xy_ff), .row_zt(y_zt_ff), .result(ty)
   );

   vpt_row u_row_z (
      .clock(clock), .enable(adv),
      .obj_x(req_obj_x), .obj_y(req_obj_y), .obj_z(req_obj_z),
      .row_xy(z_xy_ff), .row_zt(z_zt_ff), .result(tz)
   );

   vpt_div #(.FOCAL_SCALE(FOCAL_SCALE)) u_div_x (
      .clock(clock), .enable(adv), .coord(tx.value), .depth(tz.value), .quot(qx)
   );

   vpt_div #(.FOCAL_SCALE(FOCAL_SCALE)) u_div_y (
      .clock(clock), .enable(adv), .coord(ty.value), .depth(tz.value), .quot(qy)
   );

   always_comb begin
      side_in.depth = tz.value;
      side_in.zero  = tz.value == 32'sd0;
      side_in.clamp = tx.clamp | ty.clamp | tz.clamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[TOT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff    <= {last_ff[TOT-2:0], req_last_vertex};
         side_ff[0] <= side_in;
         for (int i = 1; i < DL; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_comb begin
      side_out = side_ff[DL-1];
      cx       = {8'd0, width_ff[12:1], 16'd0};
      cy       = {8'd0, height_ff[12:1], 16'd0};
      sum_x    = 36'(qx) + cx;
      sum_y    = 36'(qy) + cy;
      sx       = vpt_pkg::sat32(64'(sum_x));
      sy       = vpt_pkg::sat32(64'(sum_y));
      // zero depth: no projection, emit the screen center
      scr_x_in = side_out.zero ? 32'(cx) : sx.value;
      scr_y_in = side_out.zero ? 32'(cy) : sy.value;
      clamp_in = side_out.clamp | (!side_out.zero & (sx.clamp | sy.clamp));
      rsp_valid_in = adv ? vld_ff[TOT-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         scr_x_ff    <= scr_x_in;
         scr_y_ff    <= scr_y_in;
         dep_ff      <= side_out.depth;
         zero_ff     <= side_out.zero;
         clamp_ff    <= clamp_in;
         last_out_ff <= last_ff[TOT-1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_screen_x   = scr_x_ff;
   assign rsp_screen_y   = scr_y_ff;
   assign rsp_depth_z    = dep_ff;
   assign rsp_zero_depth = zero_ff;
   assign rsp_clamped    = clamp_ff;
   assign rsp_last_out   = last_out_ff;

   `VPT_ASSERT_IMPLIES(a_zero_center, clock, reset, rsp_valid_ff && zero_ff, scr_x_ff == 32'(cx) && scr_y_ff == 32'(cy))
   `VPT_ASSERT_IMPLIES(a_zero_depth, clock, reset, rsp_valid_ff && zero_ff, dep_ff == 32'sd0)
   `VPT_ASSERT_NEXT(a_freeze, clock, reset, rsp_valid_ff && rsp_stall, $stable(vld_ff) && $stable(last_ff))

endmodule

// ----- sim/vertex_perspective_transform_tb.sv -----
module vertex_perspective_transform_tb;

   localparam int FOCAL = 500;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 135;
   localparam int HOLD_CYCLES = 300;
   localparam logic signed [65:0] TOP32 = 66'sd2147483647;
   localparam logic signed [65:0] BOTTOM32 = -66'sd2147483648;
   localparam logic [2:0] REG_ORDER [8] = '{
      vpt_pkg::CSR_X_ROW_XY, vpt_pkg::CSR_X_ROW_ZT,
      vpt_pkg::CSR_Y_ROW_XY, vpt_pkg::CSR_Y_ROW_ZT,
      vpt_pkg::CSR_Z_ROW_XY, vpt_pkg::CSR_Z_ROW_ZT,
      vpt_pkg::CSR_FRAME_WIDTH, vpt_pkg::CSR_FRAME_HEIGHT};

   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] dz;
      logic               zero;
      logic               clamp;
      logic               batch_end;
   } screen_word_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               hit;
   } clip_word_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               batch_end;
      logic               typed;
      screen_word_type    want;
   } vertex_row_type;

   // Typed rows assume the reset matrix and a 640x480 frame (center 320,240).
   localparam vertex_row_type DIRECTED [14] = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
        '{32'h0140_0000, 32'h00F0_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0}},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1,
        '{32'h0140_0000, 32'h00F0_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b1}},
      '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b1,
        '{32'h0140_0000, 32'h00F0_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0}},
      '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1,
        '{32'h0334_0000, 32'h02E4_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b1}},
      '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b1,
        '{32'h7FFF_FFFF, 32'h00F0_0000, 32'h0000_0001, 1'b0, 1'b1, 1'b0}},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b1,
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 1'b0}},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1,
        '{32'h0334_0000, 32'h02E4_0000, 32'h8000_0000, 1'b0, 1'b0, 1'b1}},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '0},
      '{32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0, 1'b0, '0},
      '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0100, 1'b1, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 1'b1, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 1'b0, 1'b0, '0}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_obj_x;
   logic signed [31:0] req_obj_y;
   logic signed [31:0] req_obj_z;
   logic               req_last_vertex;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_screen_x;
   logic signed [31:0] rsp_screen_y;
   logic signed [31:0] rsp_depth_z;
   logic               rsp_zero_depth;
   logic               rsp_clamped;
   logic               rsp_last_out;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [63:0]        csr_data;

   // Local copy of the transform registers.
   logic [63:0]        matrix_reg [6];
   logic [12:0]        frame_w;
   logic [12:0]        frame_h;

   screen_word_type    screen_due [$];
   int                 words_outstanding;
   int                 mismatches;
   logic               typed_valid;
   screen_word_type    typed_word;
   logic               calm;
   logic               no_gaps;
   logic               hold_pending;

   vertex_perspective_transform u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_obj_x       (req_obj_x),
      .req_obj_y       (req_obj_y),
      .req_obj_z       (req_obj_z),
      .req_last_vertex (req_last_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_depth_z     (rsp_depth_z),
      .rsp_zero_depth  (rsp_zero_depth),
      .rsp_clamped     (rsp_clamped),
      .rsp_last_out    (rsp_last_out),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic clip_word_type clip32(input logic signed [65:0] v);
      clip_word_type r;
      if (v > TOP32) begin
         r = '{value: 32'sh7FFF_FFFF, hit: 1'b1};
      end else if (v < BOTTOM32) begin
         r = '{value: 32'sh8000_0000, hit: 1'b1};
      end else begin
         r = '{value: v[31:0], hit: 1'b0};
      end
      return r;
   endfunction

   // Exact Q32.32 sum, floored to Q16.16, plus translation.
   function automatic clip_word_type transform_row(input logic [63:0] xy,
                                                   input logic [63:0] zt,
                                                   input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z);
      logic signed [65:0] acc;
      acc = x * $signed(xy[31:0]) + y * $signed(xy[63:32]) + z * $signed(zt[31:0]);
      acc = (acc >>> 16) + $signed(zt[63:32]);
      return clip32(acc);
   endfunction

   function automatic clip_word_type perspective_divide(input logic signed [31:0] t,
                                                        input logic signed [31:0] z,
                                                        input logic [11:0] half);
      logic signed [63:0] ts;
      logic signed [63:0] zs;
      logic [63:0]        mt;
      logic [63:0]        mz;
      logic [63:0]        q;
      logic signed [65:0] v;
      ts = t;
      zs = z;
      mt = (ts < 0) ? -ts : ts;
      mz = (zs < 0) ? -zs : zs;
      q = ((mt * FOCAL) << 16) / mz;
      if (q > (64'd1 << 33))
         q = 64'd1 << 33;
      v = {2'b00, q};
      if ((t < 0) != (z < 0))
         v = -v;
      v = v + {38'd0, half, 16'd0};
      return clip32(v);
   endfunction

   function automatic screen_word_type project_vertex(input logic signed [31:0] x,
                                                      input logic signed [31:0] y,
                                                      input logic signed [31:0] z,
                                                      input logic batch_end);
      screen_word_type r;
      clip_word_type   tx;
      clip_word_type   ty;
      clip_word_type   tz;
      clip_word_type   px;
      clip_word_type   py;
      logic [11:0]     hx;
      logic [11:0]     hy;
      hx = frame_w[12:1];
      hy = frame_h[12:1];
      tx = transform_row(matrix_reg[vpt_pkg::CSR_X_ROW_XY],
                         matrix_reg[vpt_pkg::CSR_X_ROW_ZT], x, y, z);
      ty = transform_row(matrix_reg[vpt_pkg::CSR_Y_ROW_XY],
                         matrix_reg[vpt_pkg::CSR_Y_ROW_ZT], x, y, z);
      tz = transform_row(matrix_reg[vpt_pkg::CSR_Z_ROW_XY],
                         matrix_reg[vpt_pkg::CSR_Z_ROW_ZT], x, y, z);
      r.dz = tz.value;
      r.batch_end = batch_end;
      r.clamp = tx.hit | ty.hit | tz.hit;
      if (tz.value == 0) begin
         // no divide: park the vertex on the screen center
         r.zero = 1'b1;
         r.sx = {4'd0, hx, 16'd0};
         r.sy = {4'd0, hy, 16'd0};
      end else begin
         px = perspective_divide(tx.value, tz.value, hx);
         py = perspective_divide(ty.value, tz.value, hy);
         r.zero = 1'b0;
         r.sx = px.value;
         r.sy = py.value;
         r.clamp = r.clamp | px.hit | py.hit;
      end
      return r;
   endfunction

   function automatic logic [31:0] random_weight();
      if ($urandom_range(0, 7) == 0)
         return $urandom;
      return $signed($urandom) >>> 12;
   endfunction

   function automatic logic [31:0] random_offset();
      if ($urandom_range(0, 2) == 0)
         return 32'h0;
      return $signed($urandom) >>> 6;
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               3:       return 32'h0000_0001;
               default: return 32'h0;
            endcase
         end
         3, 4:    return $signed($urandom) >>> 14;
         default: return $signed($urandom) >>> 8;
      endcase
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Accept both channels at the rising edge; queue predictions, retire results.
   always @(posedge clock) begin
      screen_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (typed_valid)
               screen_due.push_back(typed_word);
            else
               screen_due.push_back(project_vertex(req_obj_x, req_obj_y, req_obj_z,
                                                   req_last_vertex));
         end
         if (rsp_valid && !rsp_stall) begin
            if (screen_due.size() == 0) begin
               $display("%0t: result word expected none actual %h %h %h", $time,
                        rsp_screen_x, rsp_screen_y, rsp_depth_z);
               mismatches++;
            end else begin
               want = screen_due.pop_front();
               check_field("screen_x", want.sx, rsp_screen_x);
               check_field("screen_y", want.sy, rsp_screen_y);
               check_field("depth_z", want.dz, rsp_depth_z);
               check_field("zero_depth", {31'd0, want.zero}, {31'd0, rsp_zero_depth});
               check_field("clamped", {31'd0, want.clamp}, {31'd0, rsp_clamped});
               check_field("last_out", {31'd0, want.batch_end}, {31'd0, rsp_last_out});
            end
         end
         words_outstanding = screen_due.size();
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [31:0] z, input logic batch_end,
                               input logic typed, input screen_word_type want);
      int gap;
      gap = 0;
      if (!calm && !no_gaps && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 15);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_obj_x <= x;
      req_obj_y <= y;
      req_obj_z <= z;
      req_last_vertex <= batch_end;
      typed_valid = typed;
      typed_word = want;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Drop valid and hold until every queued word has come back.
   task automatic drain_pipe();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (words_outstanding == 0);
   endtask

   task automatic load_register(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         vpt_pkg::CSR_FRAME_WIDTH:  frame_w = data[12:0];
         vpt_pkg::CSR_FRAME_HEIGHT: frame_h = data[12:0];
         default:                   matrix_reg[idx] = data;
      endcase
   endtask

   task automatic configure_phase(input int phase);
      logic [63:0] val [8];
      case (phase)
         0: begin
            val[vpt_pkg::CSR_X_ROW_XY] = vpt_pkg::RST_X_ROW_XY;
            val[vpt_pkg::CSR_X_ROW_ZT] = vpt_pkg::RST_X_ROW_ZT;
            val[vpt_pkg::CSR_Y_ROW_XY] = vpt_pkg::RST_Y_ROW_XY;
            val[vpt_pkg::CSR_Y_ROW_ZT] = vpt_pkg::RST_Y_ROW_ZT;
            val[vpt_pkg::CSR_Z_ROW_XY] = vpt_pkg::RST_Z_ROW_XY;
            val[vpt_pkg::CSR_Z_ROW_ZT] = vpt_pkg::RST_Z_ROW_ZT;
            // upper bits set, low 13 bits clear: center at zero
            val[vpt_pkg::CSR_FRAME_WIDTH] = 64'hFFFF_FFFF_FFFF_E000;
            val[vpt_pkg::CSR_FRAME_HEIGHT] = 64'hFFFF_FFFF_FFFF_E000;
         end
         1: begin
            for (int i = 0; i < 6; i++)
               val[REG_ORDER[i]] = 64'h7FFF_FFFF_7FFF_FFFF;
            val[vpt_pkg::CSR_FRAME_WIDTH] = 64'h1FFF;
            val[vpt_pkg::CSR_FRAME_HEIGHT] = 64'h1FFF;
         end
         2: begin
            for (int i = 0; i < 6; i++)
               val[REG_ORDER[i]] = 64'h8000_0000_8000_0000;
            val[vpt_pkg::CSR_FRAME_WIDTH] = 64'd4096;
            val[vpt_pkg::CSR_FRAME_HEIGHT] = 64'd1;
         end
         5: begin
            for (int i = 0; i < 8; i++)
               val[REG_ORDER[i]] = {$urandom, $urandom};
         end
         default: begin
            val[vpt_pkg::CSR_X_ROW_XY] = {random_weight(), random_weight()};
            val[vpt_pkg::CSR_X_ROW_ZT] = {random_offset(), random_weight()};
            val[vpt_pkg::CSR_Y_ROW_XY] = {random_weight(), random_weight()};
            val[vpt_pkg::CSR_Y_ROW_ZT] = {random_offset(), random_weight()};
            if ($urandom_range(0, 1) == 0) begin
               // plain depth row: depth is z plus a random offset
               val[vpt_pkg::CSR_Z_ROW_XY] = 64'h0;
               val[vpt_pkg::CSR_Z_ROW_ZT] = {random_offset(), 32'h0001_0000};
            end else begin
               val[vpt_pkg::CSR_Z_ROW_XY] = {random_weight(), random_weight()};
               val[vpt_pkg::CSR_Z_ROW_ZT] = {random_offset(), random_weight()};
            end
            if (phase == 3) begin
               val[vpt_pkg::CSR_FRAME_WIDTH] = 64'd1;
               val[vpt_pkg::CSR_FRAME_HEIGHT] = 64'd4096;
            end else if ($urandom_range(0, 3) == 0) begin
               val[vpt_pkg::CSR_FRAME_WIDTH] = {$urandom, $urandom};
               val[vpt_pkg::CSR_FRAME_HEIGHT] = {$urandom, $urandom};
            end else begin
               val[vpt_pkg::CSR_FRAME_WIDTH] = $urandom_range(1, 4096);
               val[vpt_pkg::CSR_FRAME_HEIGHT] = $urandom_range(1, 4096);
            end
         end
      endcase
      for (int i = 0; i < 8; i++)
         load_register(REG_ORDER[i], val[REG_ORDER[i]]);
   endtask

   initial begin
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      reset = 1'b1;
      req_valid = 1'b0;
      req_obj_x = '0;
      req_obj_y = '0;
      req_obj_z = '0;
      req_last_vertex = 1'b0;
      csr_write = 1'b0;
      csr_index = vpt_pkg::CSR_X_ROW_XY;
      csr_data = '0;
      typed_valid = 1'b0;
      typed_word = '0;
      calm = 1'b0;
      no_gaps = 1'b0;
      hold_pending = 1'b0;
      mismatches = 0;
      words_outstanding = 0;
      matrix_reg[vpt_pkg::CSR_X_ROW_XY] = vpt_pkg::RST_X_ROW_XY;
      matrix_reg[vpt_pkg::CSR_X_ROW_ZT] = vpt_pkg::RST_X_ROW_ZT;
      matrix_reg[vpt_pkg::CSR_Y_ROW_XY] = vpt_pkg::RST_Y_ROW_XY;
      matrix_reg[vpt_pkg::CSR_Y_ROW_ZT] = vpt_pkg::RST_Y_ROW_ZT;
      matrix_reg[vpt_pkg::CSR_Z_ROW_XY] = vpt_pkg::RST_Z_ROW_XY;
      matrix_reg[vpt_pkg::CSR_Z_ROW_ZT] = vpt_pkg::RST_Z_ROW_ZT;
      frame_w = vpt_pkg::RST_FRAME_WIDTH;
      frame_h = vpt_pkg::RST_FRAME_HEIGHT;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         offer_vertex(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z, DIRECTED[i].batch_end,
                      DIRECTED[i].typed, DIRECTED[i].want);
      drain_pipe();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == PHASES - 1)
            calm = 1'b1;
         configure_phase(phase);
         if (phase == 4) begin
            // back-pressure: result side holds off while words keep coming
            no_gaps = 1'b1;
            hold_pending = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 6 && n == PHASE_ITEMS / 2)
               drain_pipe();
            if ($urandom_range(0, 11) == 0) begin
               x = '0;
               y = '0;
               z = '0;
            end else begin
               x = random_coord();
               y = random_coord();
               z = random_coord();
            end
            offer_vertex(x, y, z, $urandom_range(0, 7) == 0, 1'b0, '0);
         end
         no_gaps = 1'b0;
         drain_pipe();
      end

      repeat (vpt_pkg::TOTAL_LAT + 8) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
